### src/wbps_pkg.sv
// Shared types, register codes and constants for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int BYTE_W         = 8;
   localparam int PATTERN_SLOTS  = 24;
   localparam int PATTERN_W      = PATTERN_SLOTS * BYTE_W;
   localparam int PAT_IDX_W      = 5;
   localparam int WILD_W         = 24;
   localparam int LEN_FIELD_W    = 5;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int MATCH_OFFSET_W = 32;

   localparam int PATTERN_MAX_DEF = 24;
   localparam int OFFSET_BITS_DEF = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_MID  = 3'd1,
      CSR_PATTERN_HIGH = 3'd2,
      CSR_WILDCARD     = 3'd3,
      CSR_LENGTH       = 3'd4
   } csr_index_type;

   // Pattern byte and wildcard flag that one cell compares against.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              wild;
   } ref_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PATTERN_W-1:0] all,
                                                      input logic [PAT_IDX_W-1:0] k);
      pattern_byte = all[{k, 3'b000} +: BYTE_W];
   endfunction

endpackage

### src/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: config registers, cell row and result stage.

// Scans an image one byte per request and reports the first position where the
// configured pattern (up to PATTERN_MAX bytes, wildcard bytes match anything)
// occurs: found=1 with the start offset, or found=0 on the last byte when the
// image held no match. One request is taken every clock cycle while req_stall is
// low; a request first shifts its byte into the row of window cells, then the
// masked compare across all cells is registered into the result register.
// Configuration must be written while no request is in flight. No clearing
// pass runs after reset.
module wildcard_byte_pattern_scanner #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_wr_en,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]      csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wbps_pkg::BYTE_W-1:0]          req_image_byte,
   input  logic                                 req_last_byte,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [wbps_pkg::MATCH_OFFSET_W-1:0]  rsp_match_offset
);

   localparam int SEEN_W = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [wbps_pkg::CSR_DATA_W-1:0]  pat_low_ff;
   logic [wbps_pkg::CSR_DATA_W-1:0]  pat_mid_ff;
   logic [wbps_pkg::CSR_DATA_W-1:0]  pat_high_ff;
   logic [wbps_pkg::WILD_W-1:0]      wild_ff;
   logic [wbps_pkg::LEN_FIELD_W-1:0] pat_len_ff;

   // image tracking
   logic [SEEN_W-1:0]      seen_ff;
   logic [SEEN_W-1:0]      seen_in;
   logic [OFFSET_BITS-1:0] pos_ff;
   logic                   reported_ff;

   // compare stage
   logic                   cmp_valid_ff;
   logic                   cmp_last_ff;
   logic [SEEN_W-1:0]      cmp_seen_ff;
   logic [OFFSET_BITS-1:0] cmp_here_ff;

   // result stage
   logic                                rsp_valid_ff;
   logic                                rsp_found_ff;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] rsp_offset_ff;

   logic                              out_free;
   logic                              cmp_move;
   logic                              accept;
   logic                              hit;
   logic                              emit;
   logic [SEEN_W-1:0]                 eff_len;
   logic [OFFSET_BITS-1:0]            start_off;
   logic [wbps_pkg::PATTERN_W-1:0]    pattern_all;
   wbps_pkg::ref_type                 refs [PATTERN_MAX];
   logic [wbps_pkg::BYTE_W-1:0]       chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]            cell_match;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cmp_move = cmp_valid_ff && out_free;
   assign req_stall = cmp_valid_ff && !out_free;
   assign accept   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_mid_ff  <= '0;
         pat_high_ff <= '0;
         wild_ff     <= '0;
         pat_len_ff  <= wbps_pkg::LEN_FIELD_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            wbps_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            wbps_pkg::CSR_PATTERN_MID:  pat_mid_ff  <= csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            wbps_pkg::CSR_WILDCARD:     wild_ff     <= csr_wdata[wbps_pkg::WILD_W-1:0];
            wbps_pkg::CSR_LENGTH:       pat_len_ff  <= csr_wdata[wbps_pkg::LEN_FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // length 0 acts as 1, anything above the window depth is clamped
   always_comb begin
      if (pat_len_ff == '0) begin
         eff_len = SEEN_W'(1);
      end else if (pat_len_ff > wbps_pkg::LEN_FIELD_W'(PATTERN_MAX)) begin
         eff_len = SEEN_W'(PATTERN_MAX);
      end else begin
         eff_len = SEEN_W'(pat_len_ff);
      end
   end

   assign pattern_all = {pat_high_ff, pat_mid_ff, pat_low_ff};

   // cell j holds window byte j (newest at 0) and checks pattern byte len-1-j
   always_comb begin
      logic [wbps_pkg::PAT_IDX_W-1:0] k;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         k = wbps_pkg::PAT_IDX_W'(eff_len) - wbps_pkg::PAT_IDX_W'(j)
             - wbps_pkg::PAT_IDX_W'(1);
         if (wbps_pkg::PAT_IDX_W'(j) < wbps_pkg::PAT_IDX_W'(eff_len)) begin
            refs[j].value = wbps_pkg::pattern_byte(pattern_all, k);
            refs[j].wild  = wild_ff[k];
         end else begin
            refs[j].value = '0;
            refs[j].wild  = 1'b1;
         end
      end
   end

   assign chain[0] = req_image_byte;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j < PATTERN_MAX - 1) begin : g_mid
         wbps_cell u_cell (
            .clock    (clock),
            .advance  (accept),
            .byte_in  (chain[j]),
            .ref_byte (refs[j]),
            .byte_out (chain[j+1]),
            .match    (cell_match[j])
         );
      end else begin : g_tail
         wbps_cell u_cell (
            .clock    (clock),
            .advance  (accept),
            .byte_in  (chain[j]),
            .ref_byte (refs[j]),
            .byte_out (),
            .match    (cell_match[j])
         );
      end
   end

   assign seen_in = (seen_ff == SEEN_W'(PATTERN_MAX)) ? seen_ff : seen_ff + SEEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         pos_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (accept) begin
         seen_ff      <= req_last_byte ? '0 : seen_in;
         pos_ff       <= req_last_byte ? '0 : pos_ff + OFFSET_BITS'(1);
         cmp_valid_ff <= 1'b1;
      end else if (cmp_move) begin
         cmp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmp_last_ff <= req_last_byte;
         cmp_seen_ff <= seen_in;
         cmp_here_ff <= pos_ff;
      end
   end

   assign hit  = cmp_valid_ff && !reported_ff && (cmp_seen_ff >= eff_len) && (&cell_match);
   assign emit = cmp_move && (hit || (cmp_last_ff && !reported_ff));
   assign start_off = cmp_here_ff - (OFFSET_BITS'(eff_len) - OFFSET_BITS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff <= 1'b0;
      end else if (cmp_move) begin
         reported_ff <= cmp_last_ff ? 1'b0 : (reported_ff | hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff  <= hit;
         rsp_offset_ff <= hit ? wbps_pkg::MATCH_OFFSET_W'(start_off) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("not-found result carries a nonzero offset");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> seen_ff == '0 && pos_ff == '0)
      else $error("image tracking not cleared after last byte");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff && reported_ff |-> !hit && !emit)
      else $error("second result within one image");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(PATTERN_MAX) &&
      (!cmp_valid_ff || cmp_seen_ff <= SEEN_W'(PATTERN_MAX)))
      else $error("window fill count beyond depth");

endmodule

### src/wbps_cell.sv
// One window cell: holds an image byte, passes it on, and compares it with its pattern byte.
module wbps_cell (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [wbps_pkg::BYTE_W-1:0]  byte_in,
   input  wbps_pkg::ref_type            ref_byte,
   output logic [wbps_pkg::BYTE_W-1:0]  byte_out,
   output logic                         match
);

   logic [wbps_pkg::BYTE_W-1:0] byte_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   assign match    = ref_byte.wild | (byte_ff == ref_byte.value);

endmodule

### dv/wildcard_byte_pattern_scanner_test.sv
// Self-checking testbench for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_test;
   import wbps_pkg::*;

   localparam int CSR_NUM_REGS    = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int LONG_HOLD       = 300;
   localparam int RANDOM_PHASES   = 14;
   localparam int PHASE_BYTES     = 82;
   localparam int MAX_IDLE        = 12;

   typedef struct packed {
      logic                      found;
      logic [MATCH_OFFSET_W-1:0] offset;
   } scan_report_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_W-1:0]         req_image_byte = '0;
   logic                      req_last_byte = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic [MATCH_OFFSET_W-1:0] rsp_match_offset;

   wildcard_byte_pattern_scanner uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_image_byte   (req_image_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

   // Scanner shadow: register copies and window state, reset values.
   logic [63:0]               pat_low = '0;
   logic [63:0]               pat_mid = '0;
   logic [63:0]               pat_high = '0;
   logic [WILD_W-1:0]         wild_mask = '0;
   logic [LEN_FIELD_W-1:0]    len_reg = 5'd1;
   logic [BYTE_W-1:0]         window [PATTERN_SLOTS];
   int                        bytes_in_window = 0;
   logic [MATCH_OFFSET_W-1:0] byte_pos = '0;
   logic                      match_seen = 1'b0;

   scan_report_type expected_reports [$];

   bit idle_off = 1'b0;
   int hold_request = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int images_sent = 0;
   int reports_checked = 0;
   int hits_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > PATTERN_SLOTS) return PATTERN_SLOTS;
      return int'(len_reg);
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_at(input int k);
      logic [3*64-1:0] all;
      all = {pat_high, pat_mid, pat_low};
      return all[k*BYTE_W +: BYTE_W];
   endfunction

   function automatic void queue_report(input logic f, input logic [MATCH_OFFSET_W-1:0] off);
      scan_report_type r;
      r.found = f;
      r.offset = off;
      expected_reports.insert(expected_reports.size(), r);
   endfunction

   // Advance the shadow by one image byte and queue the report it causes, if any.
   function automatic void predict_scan(input logic [BYTE_W-1:0] b, input logic last_in);
      logic [MATCH_OFFSET_W-1:0] here;
      int                        len;
      int                        k;
      logic                      hit;
      here = byte_pos;
      len = eff_len();
      for (k = PATTERN_SLOTS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (bytes_in_window < PATTERN_SLOTS) bytes_in_window++;
      byte_pos = here + 1'b1;
      if (!match_seen && bytes_in_window >= len) begin
         hit = 1'b1;
         for (k = 0; k < len; k++) begin
            if (!wild_mask[k] && window[len-1-k] != pattern_at(k)) hit = 1'b0;
         end
         if (hit) begin
            match_seen = 1'b1;
            queue_report(1'b1, here - MATCH_OFFSET_W'(len - 1));
         end
      end
      if (last_in) begin
         // no match anywhere in the image: the final byte reports not found
         if (!match_seen) queue_report(1'b0, '0);
         bytes_in_window = 0;
         byte_pos = '0;
         match_seen = 1'b0;
      end
   endfunction

   // Leaves csr_wr_en high; the caller lowers it after the last write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (csr_index_type'(idx))
         CSR_PATTERN_LOW:  pat_low = data;
         CSR_PATTERN_MID:  pat_mid = data;
         CSR_PATTERN_HIGH: pat_high = data;
         CSR_WILDCARD:     wild_mask = data[WILD_W-1:0];
         CSR_LENGTH:       len_reg = data[LEN_FIELD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      // bytes that cause no report may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_scanner(input logic [63:0] low, input logic [63:0] mid,
                                  input logic [63:0] high, input logic [63:0] mask,
                                  input logic [63:0] len);
      drain_reports();
      write_csr(CSR_PATTERN_LOW, low);
      write_csr(CSR_PATTERN_MID, mid);
      write_csr(CSR_PATTERN_HIGH, high);
      write_csr(CSR_WILDCARD, mask);
      write_csr(CSR_LENGTH, len);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_request(input logic [BYTE_W-1:0] b, input logic last_in);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_image_byte <= b;
      req_last_byte <= last_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_scan(b, last_in);
      bytes_sent++;
      if (last_in) images_sent++;
   endtask

   // Mostly images with the pattern planted at a random spot, some near misses, some noise.
   task automatic scan_random_image();
      logic [BYTE_W-1:0] img [];
      int                n;
      int                elen;
      int                at;
      int                k;
      int                mode;
      elen = eff_len();
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(20, 70);
      img = new[n];
      mode = $urandom_range(0, 9);
      for (k = 0; k < n; k++) begin
         if (mode == 9 || $urandom_range(0, 1) == 1) img[k] = BYTE_W'($urandom);
         else img[k] = pattern_at($urandom_range(0, elen - 1));
      end
      if (mode < 9 && n >= elen) begin
         at = $urandom_range(0, n - elen);
         for (k = 0; k < elen; k++) begin
            img[at+k] = wild_mask[k] ? BYTE_W'($urandom) : pattern_at(k);
         end
         if (mode >= 7) begin
            k = $urandom_range(0, elen - 1);
            img[at+k] = img[at+k] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
      for (k = 0; k < n; k++) send_request(img[k], k == n - 1);
   endtask

   task automatic test_default_settings();
      // reset pattern is a single 0x00 byte
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b1);
   endtask

   task automatic test_short_and_tail_match();
      program_scanner(64'h0000_0000_4433_2211, '0, '0, '0, 64'd4);
      send_request(8'h11, 1'b0);
      send_request(8'h22, 1'b1);
      send_request(8'h11, 1'b0);
      send_request(8'h22, 1'b0);
      send_request(8'h33, 1'b0);
      send_request(8'h44, 1'b1);
   endtask

   task automatic test_wildcard_bytes();
      // middle byte is wild; unused bytes and mask bits above length are junk
      program_scanner(64'hFFFF_FFFF_FF5A_00A5, '1, '1, 64'h0000_0000_00FF_FFFA, 64'd3);
      send_request(8'hA5, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'hA5, 1'b0);
      send_request(8'h7E, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'hA5, 1'b0);
      send_request(8'h5A, 1'b1);
   endtask

   task automatic test_length_limits();
      int i;
      drain_reports();
      // unmapped indexes must not disturb anything
      for (i = CSR_NUM_REGS; i < (1 << CSR_INDEX_W); i++) write_csr(CSR_INDEX_W'(i), '1);
      // length field of zero acts as one
      program_scanner(64'h0000_0000_0000_00FF, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFE0);
      send_request(8'h12, 1'b0);
      send_request(8'hFF, 1'b1);
   endtask

   task automatic test_config_between_bytes();
      program_scanner(64'h0000_0000_0000_0201, '0, '0, '0, 64'd2);
      send_request(8'h01, 1'b0);
      send_request(8'h01, 1'b0);
      // window survives the rewrite
      program_scanner(64'h0000_0000_0000_0301, '0, '0, '0, 64'd2);
      send_request(8'h03, 1'b1);
   endtask

   task automatic test_backpressure();
      int i;
      program_scanner('0, '0, '0, '1, 64'd1);
      idle_off = 1'b1;
      hold_request = LONG_HOLD;
      for (i = 0; i < 24; i++) send_request(BYTE_W'($urandom), i % 3 != 1);
      drain_reports();
      idle_off = 1'b0;
   endtask

   task automatic test_random_images();
      int          p;
      int          phase_end;
      logic [63:0] low;
      logic [63:0] mid;
      logic [63:0] high;
      logic [63:0] mask;
      logic [63:0] len;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         low = {$urandom, $urandom};
         mid = {$urandom, $urandom};
         high = {$urandom, $urandom};
         mask = {$urandom, $urandom & $urandom};
         len = {$urandom, $urandom};
         case (p)
            0: len = 64'd24;
            1: begin
               low = '1;
               mid = '1;
               high = '1;
               len = '1;
            end
            2: begin
               low = '0;
               mid = '0;
               high = '0;
               len = 64'd1;
            end
            3: len = {$urandom, $urandom & ~32'h1F};
            4: mask = '1;
            5: mask = '0;
            default: ;
         endcase
         idle_off = (p % 4 == 3);
         program_scanner(low, mid, high, mask, len);
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) begin
            scan_random_image();
            if ($urandom_range(0, 7) == 0) drain_reports();
         end
      end
      idle_off = 1'b0;
   endtask

   // Result side: random hold-off per report, plus a long hold on request.
   initial begin
      scan_report_type want;
      int              hold;
      int              long_left;
      hold = 0;
      long_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            reports_checked++;
            if (expected_reports.size() == 0) begin
               $error("unexpected report: found=%0d match_offset=%0d",
                      rsp_found, rsp_match_offset);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  error_count++;
               end
               if (rsp_match_offset !== want.offset) begin
                  $error("match_offset: expected %0d, got %0d", want.offset, rsp_match_offset);
                  error_count++;
               end
               if (want.found) hits_seen++;
            end
            hold = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (hold_request > 0) begin
            long_left = hold_request;
            hold_request = 0;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: too long without any request or report moving.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_short_and_tail_match();
      test_wildcard_bytes();
      test_length_limits();
      test_config_between_bytes();
      test_backpressure();
      test_random_images();
      drain_reports();
      $display("Scanned %0d bytes in %0d images over %0d register settings", bytes_sent,
               images_sent, settings_used);
      $display("Checked %0d reports (%0d matches), wildcards, length clamps, back-pressure",
               reports_checked, hits_seen);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/wbps_pkg.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_scanner.sv
dv/wildcard_byte_pattern_scanner_test.sv
